// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

`endif

// ----- rtl/rbc_pkg.sv -----
// types and constants of the red blob centroid unit
package rbc_pkg;

   localparam int COLOR_W = 8;
   localparam int COORD_W = 10;
   localparam int COUNT_W = 21;
   localparam int CSR_IDX_W = 2;

   localparam int FRAME_SIDE_DEFAULT = 1024;

   localparam logic [COUNT_W-1:0] MIN_RED_COUNT_RESET = COUNT_W'(20);
   localparam logic [COORD_W-1:0] FALLBACK_X_RESET = COORD_W'(50);
   localparam logic [COORD_W-1:0] FALLBACK_Y_RESET = COORD_W'(700);

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RED_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK_X = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK_Y = CSR_IDX_W'(2);

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] centroid_x;
      logic [COORD_W-1:0] centroid_y;
      logic               found;
      logic [COUNT_W-1:0] red_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV_X = 4'b0010,
      ST_DIV_Y = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// ----- rtl/red_blob_centroid_unit.sv -----
// red pixel centroid tracker with a shared iterative divider
// a pixel without frame end is taken, one pixel per clock while the unit is idle
// on frame end the request side stalls through the divider states and the done state, longer
// while rsp_stall holds the result register, set by the one-bit-a-cycle divider, x then y
// the result is registered from the done state, with the fallback values when no division runs
// synchronous active-high reset clears accumulators, control state and csr defaults
`include "assert_macros.svh"

module red_blob_centroid_unit #(
   parameter int FRAME_SIDE = rbc_pkg::FRAME_SIDE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rbc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rbc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [rbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rbc_pkg::COUNT_W-1:0]   csr_wdata
);

   localparam int QW = $clog2(FRAME_SIDE);
   localparam int SW = rbc_pkg::COUNT_W + QW;
   localparam int CW = (QW > 1) ? $clog2(QW) : 1;
   localparam int CRD = rbc_pkg::COORD_W;
   localparam int CNT = rbc_pkg::COUNT_W;
   localparam logic [CRD:0] SIDE = (CRD + 1)'(FRAME_SIDE);

   rbc_pkg::state_type state_ff, state_in;

   logic [CNT-1:0] min_count_ff, min_count_in;
   logic [CRD-1:0] fallback_x_ff, fallback_x_in;
   logic [CRD-1:0] fallback_y_ff, fallback_y_in;

   logic [CNT-1:0] count_ff, count_in;
   logic [SW-1:0]  col_sum_ff, col_sum_in;
   logic [SW-1:0]  row_sum_ff, row_sum_in;

   logic [CNT-1:0] div_count_ff, div_count_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [SW-1:0]  trial_ff, trial_in;
   logic [SW-1:0]  ysum_ff, ysum_in;
   logic [QW-1:0]  quot_ff, quot_in;
   logic [CW-1:0]  step_ff, step_in;
   logic [QW-1:0]  cx_ff, cx_in;
   logic           found_ff, found_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rbc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic           take;
   logic           in_frame;
   logic           is_red;
   logic           hit;
   logic [CNT-1:0] cnt_nxt;
   logic [SW-1:0]  col_nxt;
   logic [SW-1:0]  row_nxt;
   logic           ge;
   logic [QW-1:0]  quot_step;
   logic           last_take;
   logic           acc_empty;
   logic           div_busy;
   logic           rsp_found;

   assign req_stall = (state_ff != rbc_pkg::ST_IDLE);
   assign take = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign in_frame = ({1'b0, req_data.column} < SIDE) && ({1'b0, req_data.row} < SIDE);
   assign is_red = ({1'b0, req_data.red} > {req_data.green, 1'b0})
                && ({1'b0, req_data.red} > {req_data.blue, 1'b0});
   assign hit = in_frame && is_red && !(&count_ff);
   assign cnt_nxt = count_ff + CNT'(hit);
   assign col_nxt = col_sum_ff + (hit ? SW'(req_data.column) : SW'(0));
   assign row_nxt = row_sum_ff + (hit ? SW'(req_data.row) : SW'(0));

   // shared compare and quotient bit step of the divider
   assign ge = (rem_ff >= trial_ff);
   assign quot_step = (quot_ff << 1) | QW'(ge);

   always_comb begin
      state_in = state_ff;
      min_count_in = min_count_ff;
      fallback_x_in = fallback_x_ff;
      fallback_y_in = fallback_y_ff;
      count_in = count_ff;
      col_sum_in = col_sum_ff;
      row_sum_in = row_sum_ff;
      div_count_in = div_count_ff;
      rem_in = rem_ff;
      trial_in = trial_ff;
      ysum_in = ysum_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      cx_in = cx_ff;
      found_in = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            rbc_pkg::CSR_MIN_RED_COUNT: min_count_in = csr_wdata;
            rbc_pkg::CSR_FALLBACK_X:    fallback_x_in = csr_wdata[CRD-1:0];
            rbc_pkg::CSR_FALLBACK_Y:    fallback_y_in = csr_wdata[CRD-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rbc_pkg::ST_IDLE: begin
            if (take) begin
               count_in = cnt_nxt;
               col_sum_in = col_nxt;
               row_sum_in = row_nxt;
               if (req_data.frame_end) begin
                  count_in = '0;
                  col_sum_in = '0;
                  row_sum_in = '0;
                  div_count_in = cnt_nxt;
                  rem_in = col_nxt;
                  ysum_in = row_nxt;
                  trial_in = SW'(cnt_nxt) << (QW - 1);
                  step_in = CW'(QW - 1);
                  quot_in = '0;
                  found_in = (cnt_nxt > min_count_ff);
                  state_in = (cnt_nxt > min_count_ff) ? rbc_pkg::ST_DIV_X
                                                      : rbc_pkg::ST_DONE;
               end
            end
         end
         rbc_pkg::ST_DIV_X: begin
            if (ge) begin
               rem_in = rem_ff - trial_ff;
            end
            quot_in = quot_step;
            trial_in = trial_ff >> 1;
            step_in = step_ff - CW'(1);
            if (step_ff == '0) begin
               cx_in = quot_step;
               rem_in = ysum_ff;
               trial_in = SW'(div_count_ff) << (QW - 1);
               step_in = CW'(QW - 1);
               quot_in = '0;
               state_in = rbc_pkg::ST_DIV_Y;
            end
         end
         rbc_pkg::ST_DIV_Y: begin
            if (ge) begin
               rem_in = rem_ff - trial_ff;
            end
            quot_in = quot_step;
            trial_in = trial_ff >> 1;
            step_in = step_ff - CW'(1);
            if (step_ff == '0) begin
               state_in = rbc_pkg::ST_DONE;
            end
         end
         rbc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.found = found_ff;
               rsp_data_in.red_total = div_count_ff;
               if (found_ff) begin
                  rsp_data_in.centroid_x = CRD'(cx_ff);
                  rsp_data_in.centroid_y = CRD'(quot_ff);
               end else begin
                  rsp_data_in.centroid_x = fallback_x_ff;
                  rsp_data_in.centroid_y = fallback_y_ff;
               end
               state_in = rbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbc_pkg::ST_IDLE;
         min_count_ff <= rbc_pkg::MIN_RED_COUNT_RESET;
         fallback_x_ff <= rbc_pkg::FALLBACK_X_RESET;
         fallback_y_ff <= rbc_pkg::FALLBACK_Y_RESET;
         count_ff <= '0;
         col_sum_ff <= '0;
         row_sum_ff <= '0;
         div_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_count_ff <= min_count_in;
         fallback_x_ff <= fallback_x_in;
         fallback_y_ff <= fallback_y_in;
         count_ff <= count_in;
         col_sum_ff <= col_sum_in;
         row_sum_ff <= row_sum_in;
         div_count_ff <= div_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff <= rem_in;
      trial_ff <= trial_in;
      ysum_ff <= ysum_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      cx_ff <= cx_in;
      found_ff <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign last_take = take && req_data.frame_end;
   assign acc_empty = (count_ff == '0) && (col_sum_ff == '0) && (row_sum_ff == '0);
   assign div_busy = (state_ff == rbc_pkg::ST_DIV_X) || (state_ff == rbc_pkg::ST_DIV_Y);
   assign rsp_found = rsp_valid_ff && rsp_data_ff.found;

   `ASSERT_NEXT(a_frame_clears, clock, reset, last_take, acc_empty)
   `ASSERT_SAME(a_found_nonzero, clock, reset, rsp_found, rsp_data_ff.red_total != '0)
   `ASSERT_SAME(a_div_nonzero, clock, reset, div_busy, div_count_ff != '0)

endmodule
